// ===== rtl/ces_pkg.sv =====
package ces_pkg;

  localparam int DEF_EVENT_SLOTS = 32;
  localparam int MAX_RESULTS     = 32;
  localparam int CMD_W           = 2;
  localparam int AMOUNT_W        = 48;
  localparam int FREQ_W          = 12;
  localparam int TIME_W          = 64;
  localparam int MASK_W          = 32;
  localparam int IDX_OUT_W       = 5;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 12'd25;
  localparam logic [TIME_W-1:0] NEVER      = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ADVANCE    = 2'd0,
    CMD_SCHEDULE   = 2'd1,
    CMD_RESCHEDULE = 2'd2,
    CMD_CANCEL     = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADV,
    ST_FIRE_RD,
    ST_FIRE,
    ST_ARM,
    ST_WALK,
    ST_LINK,
    ST_ACK
  } state_t;

  // Saturating 64-bit add; an overflow means never.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? NEVER : s[TIME_W-1:0];
  endfunction

endpackage

// ===== rtl/ces_ram.sv =====
module ces_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ces_front.sv =====
module ces_front import ces_pkg::*; #(
  parameter int EVENT_SLOTS = DEF_EVENT_SLOTS,
  parameter int IW = $clog2(EVENT_SLOTS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [4:0]          event_index,
  input  logic [AMOUNT_W-1:0] amount,
  input  logic                in_microseconds,
  input  logic                q_pop,
  output logic                q_valid,
  output logic                q_full,
  output logic [CMD_W-1:0]    q_cmd,
  output logic [IW-1:0]       q_idx,
  output logic                q_act,
  output logic [AMOUNT_W-1:0] q_amount,
  output logic                q_us
);

  // Two-entry request queue; a slot command on a null or out-of-range slot is
  // marked inactive here so the back end only acknowledges it.
  logic [CMD_W-1:0]    f_cmd [2];
  logic [IW-1:0]       f_idx [2];
  logic                f_act [2];
  logic [AMOUNT_W-1:0] f_amt [2];
  logic                f_us  [2];
  logic                wp, rp;
  logic [1:0]          cnt;
  logic                push, act;

  assign push = start && !q_full;
  assign act  = (event_index != 5'd0) && ({27'd0, event_index} < EVENT_SLOTS);
  assign q_full  = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_cmd    = f_cmd[rp];
  assign q_idx    = f_idx[rp];
  assign q_act    = f_act[rp];
  assign q_amount = f_amt[rp];
  assign q_us     = f_us[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      f_cmd[wp] <= cmd;
      f_idx[wp] <= IW'(event_index);
      f_act[wp] <= act;
      f_amt[wp] <= amount;
      f_us[wp]  <= in_microseconds;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (q_pop) rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== rtl/ces_back.sv =====
module ces_back import ces_pkg::*; #(
  parameter int EVENT_SLOTS = DEF_EVENT_SLOTS,
  parameter int IW = $clog2(EVENT_SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [FREQ_W-1:0]    freq,
  input  logic                 q_valid,
  input  logic [CMD_W-1:0]     q_cmd,
  input  logic [IW-1:0]        q_idx,
  input  logic                 q_act,
  input  logic [AMOUNT_W-1:0]  q_amount,
  input  logic                 q_us,
  output logic                 q_pop,
  output logic                 result_valid,
  output logic                 kind,
  output logic [IDX_OUT_W-1:0] fired_event,
  output logic                 last,
  output logic [MASK_W-1:0]    pending_mask
);

  localparam int NW = (EVENT_SLOTS > MASK_W) ? EVENT_SLOTS : MASK_W;
  localparam int RC_W = $clog2(MAX_RESULTS + 1);

  state_t state, state_next;

  // Small per-slot tables: links and valid bits in flip-flops.
  logic [IW-1:0]     nxt [EVENT_SLOTS];
  logic [IW-1:0]     prv [EVENT_SLOTS];
  logic [NW-1:0]     queued;
  logic [NW-1:0]     dl_valid;
  logic [IW-1:0]     head;
  logic [TIME_W-1:0] now;

  // Deadline store, read one entry per cycle.
  logic              dl_we;
  logic [IW-1:0]     dl_waddr, dl_raddr;
  logic [TIME_W-1:0] dl_wdata, dl_rdata, dl_rd;
  logic [IW-1:0]     rd_addr_q;

  ces_ram #(.WIDTH(TIME_W), .DEPTH(EVENT_SLOTS)) u_dl (
    .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .raddr(dl_raddr), .rdata(dl_rdata)
  );
  assign dl_rd = dl_valid[rd_addr_q] ? dl_rdata : NEVER;

  // Working registers of the current request.
  logic [CMD_W-1:0]    c_cmd;
  logic [IW-1:0]       c_idx;
  logic [AMOUNT_W-1:0] c_amt;
  logic                c_us;
  logic [TIME_W-1:0]   delay;
  logic [TIME_W-1:0]   newdl;
  logic [IW-1:0]       wp_prev, wp_cur;
  logic [RC_W-1:0]     fired;
  logic [IW:0]         guard;
  logic [TIME_W-1:0]   base_q;
  logic [TIME_W-1:0]   dl_rd_old;

  logic [IW-1:0] ip, in_n;
  logic          unl;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (cmd_t'(c_cmd) == CMD_ADVANCE) state_next = ST_ADV;
        else if (!q_act || cmd_t'(c_cmd) == CMD_CANCEL) state_next = ST_ACK;
        else state_next = ST_ARM;
      end
      ST_ADV: state_next = ST_FIRE_RD;
      ST_FIRE_RD: state_next = ST_FIRE;
      ST_FIRE: begin
        if (head == '0 || fired == RC_W'(MAX_RESULTS - 1) || dl_rd == NEVER ||
            dl_rd > now) state_next = ST_ACK;
        else state_next = ST_FIRE_RD;
      end
      ST_ARM: state_next = ST_WALK;
      ST_WALK: begin
        if (wp_cur == '0 || !(dl_rd < newdl) || guard == (IW+1)'(EVENT_SLOTS))
          state_next = ST_LINK;
      end
      ST_LINK: state_next = ST_ACK;
      ST_ACK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and store controls.
  always_comb begin
    q_pop    = (state == ST_ACK);
    dl_we    = 1'b0;
    dl_waddr = c_idx;
    dl_wdata = newdl;
    dl_raddr = head;
    unique case (state)
      // The old deadline of the waiting request is read while it is taken.
      ST_IDLE: dl_raddr = q_idx;
      ST_ADV, ST_FIRE: dl_raddr = head;
      ST_FIRE_RD: dl_raddr = head;
      ST_MUL: dl_raddr = c_idx;
      ST_ARM: begin
        dl_raddr = head;
        dl_we    = 1'b1;
      end
      ST_WALK: dl_raddr = nxt[wp_cur];
      default: dl_raddr = head;
    endcase
  end

  // Unlink fields for the slot being armed or cancelled.
  assign unl  = queued[c_idx];
  assign ip   = prv[c_idx];
  assign in_n = nxt[c_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      queued   <= '0;
      dl_valid <= '0;
      head     <= '0;
      now      <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < EVENT_SLOTS; i++) begin
        nxt[i] <= '0;
        prv[i] <= '0;
      end
    end else begin
      state <= state_next;
      rd_addr_q <= dl_raddr;
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (q_valid) begin
          c_cmd <= q_cmd;
          c_idx <= q_idx;
          c_amt <= q_amount;
          c_us  <= q_us;
          fired <= '0;
        end
        ST_MUL: begin
          // Delay scaling, one 48x12 product.
          delay <= c_us ? TIME_W'(c_amt * freq) : TIME_W'(c_amt);
          if (cmd_t'(c_cmd) == CMD_ADVANCE) begin
            now <= sat_add(now, TIME_W'(c_amt));
          end else if (q_act && unl) begin
            if (head == c_idx) head <= in_n;
            if (ip != '0) nxt[ip] <= in_n;
            if (in_n != '0) prv[in_n] <= ip;
            prv[c_idx] <= '0;
            nxt[c_idx] <= '0;
            queued[c_idx] <= 1'b0;
          end
        end
        ST_ADV: ;
        ST_FIRE_RD: ;
        ST_FIRE: begin
          if (state_next == ST_FIRE_RD) begin
            head <= nxt[head];
            if (nxt[head] != '0) prv[nxt[head]] <= '0;
            nxt[head] <= '0;
            queued[head] <= 1'b0;
            fired <= fired + 1'b1;
            result_valid <= 1'b1;
            kind <= 1'b0;
            fired_event <= IDX_OUT_W'(head);
            last <= 1'b0;
            pending_mask <= MASK_W'(queued & ~(NW'(1) << head));
          end
        end
        ST_ARM: begin
          dl_valid[c_idx] <= 1'b1;
          wp_prev <= '0;
          wp_cur  <= head;
          guard   <= '0;
        end
        ST_WALK: begin
          if (state_next == ST_WALK) begin
            wp_prev <= wp_cur;
            wp_cur  <= nxt[wp_cur];
            guard   <= guard + 1'b1;
          end
        end
        ST_LINK: begin
          prv[c_idx] <= wp_prev;
          nxt[c_idx] <= wp_cur;
          if (wp_prev != '0) nxt[wp_prev] <= c_idx;
          else head <= c_idx;
          if (wp_cur != '0) prv[wp_cur] <= c_idx;
          queued[c_idx] <= 1'b1;
        end
        ST_ACK: begin
          result_valid <= 1'b1;
          kind <= 1'b1;
          fired_event <= '0;
          last <= 1'b1;
          pending_mask <= MASK_W'(queued);
        end
        default: ;
      endcase
    end
  end

  // New deadline; the old one is read from the store during the scaling cycle.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) base_q <= now;
  end
  always_comb begin
    if (cmd_t'(c_cmd) == CMD_RESCHEDULE) newdl = sat_add(dl_rd_old, delay);
    else newdl = sat_add(base_q, delay);
  end
  always_ff @(posedge clk) begin
    if (state == ST_MUL) dl_rd_old <= dl_valid[c_idx] ? dl_rdata : NEVER;
  end

endmodule

// ===== rtl/cycle_event_scheduler.sv =====
// Cycle event scheduler: a sorted queue of timer events against a 64-bit
// cycle counter.
// Requests enter on start/cmd/event_index/amount/in_microseconds and are
// taken at an edge where start is high and busy is low. A two-entry queue
// holds requests for the back end, which runs one request at a time.
// Results leave on result_valid with kind, fired_event, last and
// pending_mask, one cycle each; the receiver cannot stall them.
// Every request ends with one acknowledge (kind 1, last 1). An advance first
// fires each due event in deadline order, at most 31 of them. A cancel or
// null-slot request goes from scaling straight to acknowledge; a schedule
// adds arm, a walk past each queued event that its deadline passes, and
// link; an advance adds an advance step and a read and fire per fired
// event. Insertion walks the linked list one slot per cycle through the
// deadline store's read port. The back end takes the next queued request
// in the same cycle as an acknowledge is output; busy is high while both
// queue entries are in use. The user is to write the frequency register
// on cfg_valid/cfg_ready only while idle; the block does not enforce it.
// Reset empties the queue, clears the counter and sets the frequency to 25.
module cycle_event_scheduler import ces_pkg::*; #(
  parameter int EVENT_SLOTS = DEF_EVENT_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [4:0]           event_index,
  input  logic [AMOUNT_W-1:0]  amount,
  input  logic                 in_microseconds,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [FREQ_W-1:0]    cfg_data,
  output logic                 result_valid,
  output logic                 kind,
  output logic [IDX_OUT_W-1:0] fired_event,
  output logic                 last,
  output logic [MASK_W-1:0]    pending_mask
);

  localparam int IW = $clog2(EVENT_SLOTS);

  logic                q_valid, q_full, q_pop, q_act, q_us;
  logic [CMD_W-1:0]    q_cmd;
  logic [IW-1:0]       q_idx;
  logic [AMOUNT_W-1:0] q_amount;
  logic [FREQ_W-1:0]   freq;

  assign busy = q_full;
  assign cfg_ready = 1'b1;

  // Frequency register.
  always_ff @(posedge clk) begin
    if (rst) freq <= FREQ_RESET;
    else if (cfg_valid && cfg_ready) freq <= cfg_data;
  end

  ces_front #(.EVENT_SLOTS(EVENT_SLOTS), .IW(IW)) u_front (
    .clk, .rst, .start, .cmd, .event_index, .amount, .in_microseconds,
    .q_pop, .q_valid, .q_full, .q_cmd, .q_idx, .q_act, .q_amount, .q_us
  );

  ces_back #(.EVENT_SLOTS(EVENT_SLOTS), .IW(IW)) u_back (
    .clk, .rst, .freq, .q_valid, .q_cmd, .q_idx, .q_act, .q_amount, .q_us,
    .q_pop, .result_valid, .kind, .fired_event, .last, .pending_mask
  );

endmodule

// ===== rtl/ces_checker.sv =====
module ces_checker import ces_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 kind,
  input logic [IDX_OUT_W-1:0] fired_event,
  input logic                 last,
  input logic [MASK_W-1:0]    pending_mask
);

  // An acknowledge always closes a request and names no slot.
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind |-> last && fired_event == '0)
    else $error("acknowledge malformed");

  // A fired event is never the final result.
  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !kind |-> !last && fired_event != '0)
    else $error("fired event malformed");

  // A fired event is no longer pending.
  a_fire_removed: assert property (@(posedge clk) disable iff (rst)
    result_valid && !kind |-> !pending_mask[fired_event])
    else $error("fired event still pending");

  // Null slot is never pending.
  a_null: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !pending_mask[0])
    else $error("null slot pending");

endmodule

bind cycle_event_scheduler ces_checker u_ces_checker (
  .clk, .rst, .result_valid, .kind, .fired_event, .last, .pending_mask
);
